// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the flow table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside of reset.
`define RMFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define RMFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/rmft_pkg.sv =====
// Types, constants and helper functions of the range match flow table.
package rmft_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ADDR_W   = 10;
  localparam int PORT_W   = 3;
  localparam int HITS_W   = 32;
  localparam int STATUS_W = 3;
  localparam int RIDX_W   = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [PORT_W-1:0] LOCAL_PORT = 3'd3;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [STATUS_W-1:0] STS_FORWARD  = 3'd0;
  localparam logic [STATUS_W-1:0] STS_DROP     = 3'd1;
  localparam logic [STATUS_W-1:0] STS_MISS     = 3'd2;
  localparam logic [STATUS_W-1:0] STS_INSERTED = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FULL     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_HIGH = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [ADDR_W-1:0]   dest_address;
    logic [ADDR_W-1:0]   range_low;
    logic [ADDR_W-1:0]   range_high;
    logic                forward_flag;
    logic [PORT_W-1:0]   port_number;
    logic [HITS_W-1:0]   initial_count;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RIDX_W-1:0]   rule_index;
    logic [PORT_W-1:0]   out_port;
    logic [HITS_W-1:0]   hit_count;
  } out_item_t;

  // One stored rule, one RAM word.
  typedef struct packed {
    logic [ADDR_W-1:0] low;
    logic [ADDR_W-1:0] high;
    logic              action;
    logic [PORT_W-1:0] port;
    logic [HITS_W-1:0] hits;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } rmft_state_t;

  function automatic logic [HITS_W-1:0] sat_inc(input logic [HITS_W-1:0] v);
    return (v == {HITS_W{1'b1}}) ? v : v + HITS_W'(1);
  endfunction

  // Rule number as reported: keep the low byte.
  function automatic logic [RIDX_W-1:0] to_rule_index(input logic [CNT_W-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    return wide[RIDX_W-1:0];
  endfunction

endpackage

// ===== hdl/rmft_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module rmft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/range_match_flow_table_top.sv =====
// Top level of the first-match range flow table: sequencer, counters and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in_     | input     | in_valid/in_stall  | in_item  (rmft_pkg::in_item_t)
//  out_    | output    | out_valid/out_stall| out_item (rmft_pkg::out_item_t)
//  cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// An insert or a lookup that hits the local rule puts its result into the result
// register at accept. Any other lookup walks the rule RAM one entry a cycle from
// the first rule until it hits or runs out of rules; the single read port of the
// rule RAM paces the walk. in_stall stays high from accept until the result moves
// into the output register, so a new beat is taken only after the last result
// has moved there, and a stalled out_ holds the finished result back until that
// register is free.
// Reset (rst_n low, synchronous) clears the rule count, the local hit counter
// and the local range; rule RAM contents need no clearing.
// A held result on out_ does not block the next accept; the sequencer only
// waits in its final step until the result register is free.
module range_match_flow_table_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rmft_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rmft_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [rmft_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rmft_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import rmft_pkg::*;

`include "assert_macros.svh"

  rmft_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0] local_low_r, local_high_r;
  logic [HITS_W-1:0] local_hits_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  ptr_r;
  logic              cmp_valid_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic [ADDR_W-1:0] addr_r;
  out_item_t         res_r, res_nxt;
  logic              res_load;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  rule_t             ram_wdata;
  logic [RULE_W-1:0] ram_rdata;
  rule_t             rd_rule;

  logic in_accept, is_insert, table_full, local_hit;
  logic rule_hit, scan_miss, out_free;
  logic cnt_inc, local_inc, scan_start;
  logic wr_legal;

  // Rule store: range, action, port and hit counter in one word.
  rmft_ram #(
    .WIDTH(RULE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_rule_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ptr_r[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  assign rd_rule    = rule_t'(ram_rdata);
  assign in_stall   = (state_r != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign is_insert  = (in_item.operation == OP_INSERT);
  assign table_full = (cnt_r == CNT_W'(TABLE_DEPTH));
  assign local_hit  = (local_low_r <= in_item.dest_address) &&
                      (in_item.dest_address <= local_high_r);
  // Entry read last cycle is compared now; first match wins.
  assign rule_hit   = cmp_valid_r && (rd_rule.low <= addr_r) && (addr_r <= rd_rule.high);
  // No read in flight and no entry left: the walk came up empty.
  assign scan_miss  = !cmp_valid_r && (ptr_r == cnt_r);
  assign out_free   = !out_valid_r || !out_stall;
  // Rule writes come only from an accepted insert or a matched-rule write-back.
  assign wr_legal   = (state_r == S_SCAN && rule_hit) ||
                      (state_r == S_IDLE && in_accept && is_insert);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = (is_insert || local_hit) ? S_EMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (rule_hit || scan_miss) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = cnt_r[IDX_W-1:0];
    ram_wdata  = '{low: in_item.range_low, high: in_item.range_high,
                   action: in_item.forward_flag, port: in_item.port_number,
                   hits: in_item.initial_count};
    ram_re     = 1'b0;
    res_load   = 1'b0;
    res_nxt    = '0;
    cnt_inc    = 1'b0;
    local_inc  = 1'b0;
    scan_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (is_insert) begin
            res_load = 1'b1;
            if (table_full) begin
              res_nxt.status = STS_FULL;
            end else begin
              // Append at the next free slot.
              ram_we             = 1'b1;
              cnt_inc            = 1'b1;
              res_nxt.status     = STS_INSERTED;
              res_nxt.rule_index = to_rule_index(cnt_r + CNT_W'(1));
              res_nxt.hit_count  = in_item.initial_count;
            end
          end else if (local_hit) begin
            local_inc          = 1'b1;
            res_load           = 1'b1;
            res_nxt.status     = STS_FORWARD;
            res_nxt.out_port   = LOCAL_PORT;
            res_nxt.hit_count  = sat_inc(local_hits_r);
          end else begin
            scan_start = 1'b1;
          end
        end
      end
      S_SCAN: begin
        // Stop issuing reads once a match is seen.
        ram_re = (ptr_r != cnt_r) && !rule_hit;
        if (rule_hit) begin
          // Write back the bumped counter of the matched rule.
          ram_we             = 1'b1;
          ram_waddr          = cmp_idx_r;
          ram_wdata          = rd_rule;
          ram_wdata.hits     = sat_inc(rd_rule.hits);
          res_load           = 1'b1;
          res_nxt.status     = rd_rule.action ? STS_FORWARD : STS_DROP;
          res_nxt.rule_index = to_rule_index(CNT_W'(cmp_idx_r) + CNT_W'(1));
          res_nxt.out_port   = rd_rule.action ? rd_rule.port : '0;
          res_nxt.hit_count  = sat_inc(rd_rule.hits);
        end else if (scan_miss) begin
          res_load       = 1'b1;
          res_nxt.status = STS_MISS;
        end
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      local_hits_r <= '0;
      local_low_r  <= '0;
      local_high_r <= '0;
      ptr_r        <= '0;
      cmp_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_valid_r <= ram_re;
      if (cnt_inc) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (local_inc) begin
        local_hits_r <= sat_inc(local_hits_r);
      end
      if (scan_start) begin
        ptr_r <= '0;
      end else if (ram_re) begin
        ptr_r <= ptr_r + CNT_W'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOCAL_LOW:  local_low_r  <= cfg_wdata[ADDR_W-1:0];
          CFG_LOCAL_HIGH: local_high_r <= cfg_wdata[ADDR_W-1:0];
          default: begin
          end
        endcase
      end
      // Advance the finished result into the output register, drop it once taken.
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      cmp_idx_r <= ptr_r[IDX_W-1:0];
    end
    if (in_accept) begin
      addr_r <= in_item.dest_address;
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
    if (state_r == S_EMIT && out_free) begin
      out_item_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `RMFT_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(TABLE_DEPTH), "rule count beyond table depth")
  `RMFT_ASSERT(a_cmp_in_scan, cmp_valid_r |-> state_r == S_SCAN, "compare outside scan")
  `RMFT_ASSERT(a_accept_busy, in_accept |=> state_r != S_IDLE, "accepted beat not held")
  `RMFT_ASSERT(a_ram_write_src, ram_we |-> wr_legal, "stray rule write")
  `RMFT_ASSERT(a_emit_loads, (state_r == S_EMIT && out_free) |=> out_valid_r, "result not presented")

endmodule

// ===== test/tb_top.sv =====
// Testbench for the range match flow table: directed and random traffic checked beat by beat.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rmft_pkg::*;

  // Cycles with no accepted beat on either channel before the run is declared hung.
  // The slowest correct gap is a full-table miss behind the long receiver hold
  // (HOLD_CYCLES), so this leaves a wide margin.
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  range_match_flow_table_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Behavioral copy of the table: local rule, inserted rules in insert order.
  logic [ADDR_W-1:0] lcl_lo;
  logic [ADDR_W-1:0] lcl_hi;
  logic [HITS_W-1:0] lcl_hits;
  logic [ADDR_W-1:0] tbl_lo   [TABLE_DEPTH];
  logic [ADDR_W-1:0] tbl_hi   [TABLE_DEPTH];
  logic              tbl_fwd  [TABLE_DEPTH];
  logic [PORT_W-1:0] tbl_port [TABLE_DEPTH];
  logic [HITS_W-1:0] tbl_hits [TABLE_DEPTH];
  int                tbl_used;

  // Verdicts predicted at accept time, oldest first.
  out_item_t pending_verdicts[$];
  int        err_count;

  // Idle controls: sender gaps, receiver stalls, and a one-shot long receiver hold.
  bit in_idle_on;
  bit out_idle_on;
  int hold_left;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [HITS_W-1:0] bump_hits(logic [HITS_W-1:0] h);
    return (h == '1) ? h : h + HITS_W'(1);
  endfunction

  // Predict the verdict of one accepted beat and advance the table copy.
  function automatic out_item_t classify_packet(in_item_t it);
    out_item_t res;
    int i;
    res = '0;
    if (it.operation == OP_INSERT) begin
      if (tbl_used >= TABLE_DEPTH) begin
        res.status = STS_FULL;
      end else begin
        tbl_lo[tbl_used]   = it.range_low;
        tbl_hi[tbl_used]   = it.range_high;
        tbl_fwd[tbl_used]  = it.forward_flag;
        tbl_port[tbl_used] = it.port_number;
        tbl_hits[tbl_used] = it.initial_count;
        tbl_used++;
        res.status     = STS_INSERTED;
        res.rule_index = RIDX_W'(tbl_used);
        res.hit_count  = it.initial_count;
      end
      return res;
    end
    // Local rule always wins when it covers the address.
    if (lcl_lo <= it.dest_address && it.dest_address <= lcl_hi) begin
      lcl_hits       = bump_hits(lcl_hits);
      res.status     = STS_FORWARD;
      res.out_port   = LOCAL_PORT;
      res.hit_count  = lcl_hits;
      return res;
    end
    for (i = 0; i < tbl_used; i++) begin
      if (tbl_lo[i] <= it.dest_address && it.dest_address <= tbl_hi[i]) begin
        tbl_hits[i]    = bump_hits(tbl_hits[i]);
        res.status     = tbl_fwd[i] ? STS_FORWARD : STS_DROP;
        res.rule_index = RIDX_W'(i + 1);
        res.out_port   = tbl_fwd[i] ? tbl_port[i] : '0;
        res.hit_count  = tbl_hits[i];
        return res;
      end
    end
    res.status = STS_MISS;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    err_count++;
  endtask

  // Check every result beat against the oldest prediction.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected, status %0d",
                                  out_item.status));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_item.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_item.status, want.status));
        if (out_item.rule_index !== want.rule_index)
          report_mismatch($sformatf("rule_index got %0d want %0d",
                                    out_item.rule_index, want.rule_index));
        if (out_item.out_port !== want.out_port)
          report_mismatch($sformatf("out_port got %0d want %0d",
                                    out_item.out_port, want.out_port));
        if (out_item.hit_count !== want.hit_count)
          report_mismatch($sformatf("hit_count got %0h want %0h",
                                    out_item.hit_count, want.hit_count));
      end
    end
  end

  // Receiver: a requested long hold takes priority, else random stall runs.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap(out_idle_on);
      end
    end
  end

  // Hang detector: count cycles with no accepted beat on either channel.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Offer one beat after a random gap; hold it until accepted, then predict.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap(in_idle_on);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_verdicts.push_back(classify_packet(it));
  endtask

  // Drop valid and wait until every predicted beat has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_LOCAL_LOW:  lcl_lo = val;
      CFG_LOCAL_HIGH: lcl_hi = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Only called with the block idle (after a drain).
  task automatic set_local_range(input int lo, input int hi);
    write_cfg(CFG_LOCAL_LOW, CFG_DATA_W'(lo));
    write_cfg(CFG_LOCAL_HIGH, CFG_DATA_W'(hi));
  endtask

  function automatic in_item_t make_look(input int addr);
    in_item_t it;
    it = '0;
    it.operation    = OP_LOOKUP;
    it.dest_address = ADDR_W'(addr);
    return it;
  endfunction

  function automatic in_item_t make_ins(input int lo, input int hi, input bit fwd,
                                        input int port, input logic [HITS_W-1:0] cnt);
    in_item_t it;
    it = '0;
    it.operation     = OP_INSERT;
    it.range_low     = ADDR_W'(lo);
    it.range_high    = ADDR_W'(hi);
    it.forward_flag  = fwd;
    it.port_number   = PORT_W'(port);
    it.initial_count = cnt;
    return it;
  endfunction

  // Random beat: noise in every field, then shaped so lookups mostly land in
  // ranges that exist and inserts mostly carry narrow, well-formed ranges.
  function automatic in_item_t rand_item(input int insert_pct);
    in_item_t it;
    int r, k, lo;
    it.operation     = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_LOOKUP;
    it.dest_address  = ADDR_W'($urandom);
    it.range_low     = ADDR_W'($urandom);
    it.range_high    = ADDR_W'($urandom);
    it.forward_flag  = 1'($urandom);
    it.port_number   = PORT_W'($urandom);
    it.initial_count = $urandom;
    r = $urandom_range(0, 99);
    if (it.operation == OP_INSERT) begin
      if (r < 85) begin
        lo = $urandom_range(0, 1000);
        it.range_low  = ADDR_W'(lo);
        it.range_high = ADDR_W'((lo + 40 > 1023) ? 1023 : lo + $urandom_range(0, 40));
      end
      // A few counters start at or just below the saturation point.
      if ($urandom_range(0, 9) == 0) it.initial_count = '1 - $urandom_range(0, 3);
    end else begin
      if (r < 60 && tbl_used > 0) begin
        k = $urandom_range(0, tbl_used - 1);
        if (tbl_lo[k] <= tbl_hi[k])
          it.dest_address = ADDR_W'($urandom_range(tbl_hi[k], tbl_lo[k]));
      end else if (r < 75 && lcl_lo <= lcl_hi) begin
        it.dest_address = ADDR_W'($urandom_range(lcl_hi, lcl_lo));
      end
    end
    return it;
  endfunction

  // Reset state: local range 0..0, empty table.
  task automatic test_after_reset();
    send_item(make_look(0));
    send_item(make_look(1023));
    drain_results();
  endtask

  task automatic test_directed_rules();
    set_local_range(10, 20);
    send_item(make_look(15));
    send_item(make_look(10));
    send_item(make_look(21));                              // empty table: miss
    send_item(make_ins(100, 200, 1'b1, 7, 32'hFFFF_FFFE));
    send_item(make_look(100));                             // counter reaches all ones
    send_item(make_look(200));                             // and stays there
    send_item(make_ins(300, 400, 1'b0, 5, 32'd5));
    send_item(make_look(400));                             // drop match, port forced to 0
    send_item(make_ins(600, 500, 1'b1, 1, 32'd9));         // inverted range
    send_item(make_look(550));                             // never matches it
    send_item(make_ins(1001, 1023, 1'b1, 0, 32'd0));       // above the nominal top
    send_item(make_look(1023));
    send_item(make_ins(150, 160, 1'b0, 6, 32'd3));         // shadowed by the first rule
    send_item(make_look(155));
    send_item(make_ins(0, 0, 1'b1, 2, 32'd7));
    send_item(make_look(0));
    drain_results();
  endtask

  task automatic test_local_extremes();
    set_local_range(0, 1023);                              // local covers everything
    send_item(make_look(0));
    send_item(make_look(1023));
    drain_results();
    set_local_range(1023, 0);                              // local never matches
    send_item(make_look(1023));
    send_item(make_look(155));
    drain_results();
    set_local_range(1023, 1023);
    send_item(make_look(1023));
    send_item(make_look(1022));
    drain_results();
  endtask

  task automatic test_random_traffic(input int n, input int insert_pct, input bit idle);
    in_item_t it;
    int lo;
    lo = $urandom_range(0, 1023);
    if ($urandom_range(0, 4) == 0) set_local_range(lo, $urandom_range(0, 1023));
    else set_local_range(lo, (lo + 30 > 1023) ? 1023 : lo + $urandom_range(0, 30));
    in_idle_on  = idle;
    out_idle_on = idle;
    repeat (n) begin
      it = rand_item(insert_pct);
      send_item(it);
    end
    drain_results();
  endtask

  // Fill every slot, then confirm further inserts are refused.
  task automatic test_table_full();
    in_item_t it;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    while (tbl_used < TABLE_DEPTH) begin
      it = rand_item(100);
      send_item(it);
    end
    repeat (6) begin
      it = rand_item(100);
      send_item(it);
    end
    repeat (10) begin
      it = rand_item(0);
      send_item(it);
    end
    drain_results();
  endtask

  // Hold off the receiver long enough that the block backs up into in_stall,
  // then let the sender wait out every outstanding beat before resuming.
  task automatic test_backpressure();
    in_item_t it;
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    hold_left   = HOLD_CYCLES;
    repeat (30) begin
      it = rand_item(20);
      send_item(it);
    end
    drain_results();
    repeat (10) begin
      it = rand_item(20);
      send_item(it);
    end
    drain_results();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    hold_left   = 0;
    stall_left  = 0;
    err_count   = 0;
    lcl_lo      = '0;
    lcl_hi      = '0;
    lcl_hits    = '0;
    tbl_used    = 0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_directed_rules();
    test_local_extremes();
    test_random_traffic(150, 30, 1'b1);
    test_table_full();
    test_random_traffic(200, 15, 1'b1);
    test_random_traffic(150, 15, 1'b0);
    test_backpressure();
    set_local_range(0, 1023);
    test_random_traffic(50, 10, 1'b1);
    test_random_traffic(200, 20, 1'b1);

    // Give a stray result beat time to show up after the last expected one.
    drain_results();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (err_count == 0 && pending_verdicts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rmft_pkg.sv
hdl/rmft_ram.sv
hdl/range_match_flow_table_top.sv
test/tb_top.sv
